@@ sv/cicpc_pkg.sv @@
`timescale 1ns / 1ps

package cicpc_pkg;

	localparam int unsigned COORD_BITS_DEF = 16;
	localparam int unsigned PEG_BITS       = 16;
	localparam int unsigned RADIUS_BITS    = 15;
	localparam int unsigned R2_BITS        = 2 * RADIUS_BITS;
	localparam int unsigned VERDICT_BITS   = 2;
	localparam int unsigned CFG_IDX_BITS   = 2;
	localparam int unsigned CFG_DATA_BITS  = 16;
	localparam int unsigned UOP_BITS       = 5;
	localparam int unsigned MIN_VERTICES   = 3;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_PEG_X      = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PEG_Y      = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PEG_RADIUS = 2'd2;

	// verdict codes
	localparam logic [VERDICT_BITS-1:0] VERDICT_FIT     = 2'd0;
	localparam logic [VERDICT_BITS-1:0] VERDICT_NOT_FIT = 2'd1;
	localparam logic [VERDICT_BITS-1:0] VERDICT_ILL     = 2'd2;

	// turn orientation codes
	localparam logic [1:0] TURN_NONE  = 2'd0;
	localparam logic [1:0] TURN_LEFT  = 2'd1;
	localparam logic [1:0] TURN_RIGHT = 2'd2;

	// start of the edge and turn programs
	localparam logic [UOP_BITS-1:0] EDGE_START = 5'd0;
	localparam logic [UOP_BITS-1:0] TURN_START = 5'd25;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_RUN   = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_APPLY = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	typedef enum logic [2:0] {
		JOB_EDGE,
		JOB_TURN,
		JOB_EDGE_CLOSE,
		JOB_TURN_CLOSE_A,
		JOB_TURN_CLOSE_B
	} job_t;

	typedef enum logic [3:0] {
		OPD_AX, OPD_AY, OPD_BX, OPD_BY,
		OPD_EX, OPD_EY, OPD_VX, OPD_VY,
		OPD_R, OPD_R2, OPD_ONE,
		OPD_CHI, OPD_CLO, OPD_EHI, OPD_ELO
	} opd_t;

	typedef enum logic [1:0] {
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB
	} acc_mode_t;

	typedef enum logic [1:0] {
		SH_NONE,
		SH_ONE,
		SH_TWO
	} acc_shift_t;

	typedef enum logic [3:0] {
		CAP_NONE, CAP_R2, CAP_CAB, CAP_DAB, CAP_K, CAP_DA,
		CAP_DB, CAP_AN, CAP_BN, CAP_E, CAP_CN, CAP_TURN
	} cap_t;

	typedef struct packed {
		acc_mode_t  mode;
		acc_shift_t shift;
		cap_t       cap;
	} acc_ctl_t;

	typedef struct packed {
		opd_t     opa;
		opd_t     opb;
		acc_ctl_t ctl;
		logic     last;
	} uop_t;

	function automatic uop_t mk_uop(input opd_t a, input opd_t b, input acc_mode_t m,
			input acc_shift_t s, input cap_t c, input logic l);
		uop_t u;
		u.opa       = a;
		u.opb       = b;
		u.ctl.mode  = m;
		u.ctl.shift = s;
		u.ctl.cap   = c;
		u.last      = l;
		return u;
	endfunction

	// micro-program: edge test at 0..24, turn test at 25..26
	function automatic uop_t uop_rom(input logic [UOP_BITS-1:0] idx);
		uop_t u;
		u = mk_uop(OPD_ONE, OPD_ONE, ACC_LOAD, SH_NONE, CAP_NONE, 1'b1);
		case (idx)
			5'd0:  u = mk_uop(OPD_R,   OPD_R,   ACC_LOAD, SH_NONE, CAP_R2,   1'b0);
			5'd1:  u = mk_uop(OPD_AX,  OPD_BY,  ACC_LOAD, SH_NONE, CAP_NONE, 1'b0);
			5'd2:  u = mk_uop(OPD_AY,  OPD_BX,  ACC_SUB,  SH_NONE, CAP_CAB,  1'b0);
			5'd3:  u = mk_uop(OPD_AX,  OPD_BX,  ACC_LOAD, SH_NONE, CAP_NONE, 1'b0);
			5'd4:  u = mk_uop(OPD_AY,  OPD_BY,  ACC_ADD,  SH_NONE, CAP_DAB,  1'b0);
			5'd5:  u = mk_uop(OPD_EY,  OPD_AX,  ACC_LOAD, SH_NONE, CAP_NONE, 1'b0);
			5'd6:  u = mk_uop(OPD_EX,  OPD_AY,  ACC_SUB,  SH_NONE, CAP_K,    1'b0);
			5'd7:  u = mk_uop(OPD_EX,  OPD_AX,  ACC_LOAD, SH_NONE, CAP_NONE, 1'b0);
			5'd8:  u = mk_uop(OPD_EY,  OPD_AY,  ACC_ADD,  SH_NONE, CAP_DA,   1'b0);
			5'd9:  u = mk_uop(OPD_EX,  OPD_BX,  ACC_LOAD, SH_NONE, CAP_NONE, 1'b0);
			5'd10: u = mk_uop(OPD_EY,  OPD_BY,  ACC_ADD,  SH_NONE, CAP_DB,   1'b0);
			5'd11: u = mk_uop(OPD_AX,  OPD_AX,  ACC_LOAD, SH_NONE, CAP_NONE, 1'b0);
			5'd12: u = mk_uop(OPD_AY,  OPD_AY,  ACC_ADD,  SH_NONE, CAP_NONE, 1'b0);
			5'd13: u = mk_uop(OPD_R2,  OPD_ONE, ACC_SUB,  SH_NONE, CAP_AN,   1'b0);
			5'd14: u = mk_uop(OPD_BX,  OPD_BX,  ACC_LOAD, SH_NONE, CAP_NONE, 1'b0);
			5'd15: u = mk_uop(OPD_BY,  OPD_BY,  ACC_ADD,  SH_NONE, CAP_NONE, 1'b0);
			5'd16: u = mk_uop(OPD_R2,  OPD_ONE, ACC_SUB,  SH_NONE, CAP_BN,   1'b0);
			5'd17: u = mk_uop(OPD_EX,  OPD_EX,  ACC_LOAD, SH_NONE, CAP_NONE, 1'b0);
			5'd18: u = mk_uop(OPD_EY,  OPD_EY,  ACC_ADD,  SH_NONE, CAP_E,    1'b0);
			5'd19: u = mk_uop(OPD_CHI, OPD_CHI, ACC_LOAD, SH_TWO,  CAP_NONE, 1'b0);
			5'd20: u = mk_uop(OPD_CHI, OPD_CLO, ACC_ADD,  SH_ONE,  CAP_NONE, 1'b0);
			5'd21: u = mk_uop(OPD_CHI, OPD_CLO, ACC_ADD,  SH_ONE,  CAP_NONE, 1'b0);
			5'd22: u = mk_uop(OPD_CLO, OPD_CLO, ACC_ADD,  SH_NONE, CAP_NONE, 1'b0);
			5'd23: u = mk_uop(OPD_R2,  OPD_EHI, ACC_SUB,  SH_ONE,  CAP_NONE, 1'b0);
			5'd24: u = mk_uop(OPD_R2,  OPD_ELO, ACC_SUB,  SH_NONE, CAP_CN,   1'b1);
			5'd25: u = mk_uop(OPD_EX,  OPD_VY,  ACC_LOAD, SH_NONE, CAP_NONE, 1'b0);
			5'd26: u = mk_uop(OPD_EY,  OPD_VX,  ACC_SUB,  SH_NONE, CAP_TURN, 1'b1);
			default: u = mk_uop(OPD_ONE, OPD_ONE, ACC_LOAD, SH_NONE, CAP_NONE, 1'b1);
		endcase
		return u;
	endfunction

endpackage

@@ sv/circle_in_convex_polygon_check.sv @@
`timescale 1ns / 1ps
// channel  signals                                  direction  moves
// in       in_valid in_stall vertex_x vertex_y      into block one vertex item
//          last_vertex
// out      out_valid out_stall verdict              out of     one verdict item
// cfg      cfg_valid cfg_ready cfg_index cfg_data   into block one register write
//
// the first vertex of a polygon is only taken in; the second runs the edge job: the
// accepting cycle, 25 passes through the shared multiplier for the edge, a drain
// and an apply. later vertices also run the turn: 2 passes, a drain and an apply.
// the closing vertex adds the closing edge and two wrap turns, then the verdict is
// loaded in the output state.
// arst_n clears the peg registers, the polygon state and the output valid.
// in_stall is high whenever the sequencer is busy; a verdict waiting on out_stall
// holds the block only when the next verdict is ready to go out.

module circle_in_convex_polygon_check #(
	parameter int unsigned COORD_BITS = cicpc_pkg::COORD_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [COORD_BITS-1:0]           vertex_x,
	input  logic signed [COORD_BITS-1:0]           vertex_y,
	input  logic                                   last_vertex,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [cicpc_pkg::VERDICT_BITS-1:0]     verdict,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [cicpc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [cicpc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	// difference width: vertex minus peg centre, vertex minus vertex
	localparam int unsigned DW = ((COORD_BITS > cicpc_pkg::PEG_BITS) ?
		COORD_BITS : cicpc_pkg::PEG_BITS) + 1;
	// multiplier operand width, also holds r squared as a positive number
	localparam int unsigned MW = ((DW + 1) > (cicpc_pkg::R2_BITS + 1)) ?
		(DW + 1) : (cicpc_pkg::R2_BITS + 1);
	localparam int unsigned PW = 2 * MW;
	localparam int unsigned CW = 2 * DW;
	localparam int unsigned AW = 4 * DW + 2;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
	} pt_t;

	cicpc_pkg::state_t state_q;
	cicpc_pkg::job_t   job_q;
	logic [cicpc_pkg::UOP_BITS-1:0] op_q;

	// polygon state
	pt_t first_q, second_q, vbp_q, prior_q, cur_q;
	logic        last_q;
	logic [1:0]  cnt_q;
	logic [1:0]  turn_q;
	logic [15:0] wind_q;
	logic        ill_q;
	logic        misfit_q;

	// peg registers
	logic signed [cicpc_pkg::PEG_BITS-1:0]  peg_x_q, peg_y_q;
	logic [cicpc_pkg::RADIUS_BITS-1:0]      peg_radius_q;

	// job operands
	logic signed [DW-1:0] ax_q, ay_q, bx_q, by_q, ex_q, ey_q, vx_q, vy_q;

	// shared multiply-accumulate unit
	logic signed [MW-1:0] opa, opb;
	logic signed [PW-1:0] prod_s1;
	cicpc_pkg::acc_ctl_t  ctl_s1;
	logic                 vld_s1;
	logic signed [AW-1:0] acc_q, acc_nxt, acc_base, acc_term, acc_abs;
	logic                 acc_neg, acc_zero;

	// captured intermediate results
	logic [cicpc_pkg::R2_BITS-1:0] r2_q;
	logic [CW-1:0] cmag_q, e_q;
	logic cab_zero_q, dab_neg_q, k_pos_q, k_neg_q, da_neg_q, db_pos_q;
	logic an_q, bn_q, cn_q;

	cicpc_pkg::uop_t uop;

	// sequencer decisions
	logic             in_acc;
	logic             start_job;
	cicpc_pkg::job_t  start_kind;
	logic             do_shift;
	logic [1:0]       cnt_nxt;
	logic             give_verdict;
	logic [cicpc_pkg::VERDICT_BITS-1:0] verdict_nxt, pend_q;
	pt_t sel_a, sel_b, sel_c;
	logic             out_load;

	// edge results
	logic near, zero_len, ay_le0, by_le0, on_edge;
	logic [1:0] turn_code;

	// output register
	logic vld_out_q;
	logic [cicpc_pkg::VERDICT_BITS-1:0] verdict_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != cicpc_pkg::ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = vld_out_q;
	assign verdict   = verdict_q;

	assign uop = cicpc_pkg::uop_rom(op_q);

	// saturating vertex count after this vertex
	assign cnt_nxt = (cnt_q == 2'd3) ? 2'd3 : (cnt_q + 2'd1);

	// sequencer next-step decisions
	always_comb begin
		start_job    = 1'b0;
		start_kind   = cicpc_pkg::JOB_EDGE;
		do_shift     = 1'b0;
		give_verdict = 1'b0;
		verdict_nxt  = cicpc_pkg::VERDICT_ILL;
		case (state_q)
			cicpc_pkg::ST_IDLE: begin
				if (in_acc && cnt_q != 2'd0) begin
					start_job  = 1'b1;
					start_kind = cicpc_pkg::JOB_EDGE;
				end else if (in_acc && last_vertex) begin
					// mark on the very first vertex
					give_verdict = 1'b1;
				end
			end
			cicpc_pkg::ST_APPLY: begin
				case (job_q)
					cicpc_pkg::JOB_EDGE: begin
						if (cnt_q >= 2'd2) begin
							start_job  = 1'b1;
							start_kind = cicpc_pkg::JOB_TURN;
						end else begin
							do_shift = 1'b1;
						end
					end
					cicpc_pkg::JOB_TURN: do_shift = 1'b1;
					cicpc_pkg::JOB_EDGE_CLOSE: begin
						start_job  = 1'b1;
						start_kind = cicpc_pkg::JOB_TURN_CLOSE_A;
					end
					cicpc_pkg::JOB_TURN_CLOSE_A: begin
						start_job  = 1'b1;
						start_kind = cicpc_pkg::JOB_TURN_CLOSE_B;
					end
					cicpc_pkg::JOB_TURN_CLOSE_B: begin
						give_verdict = 1'b1;
						if (ill_q)
							verdict_nxt = cicpc_pkg::VERDICT_ILL;
						else if (misfit_q || wind_q == 16'd0)
							verdict_nxt = cicpc_pkg::VERDICT_NOT_FIT;
						else
							verdict_nxt = cicpc_pkg::VERDICT_FIT;
					end
					default: do_shift = 1'b0;
				endcase
				if (do_shift && last_q) begin
					if (cnt_nxt < 2'(cicpc_pkg::MIN_VERTICES)) begin
						give_verdict = 1'b1;
					end else begin
						start_job  = 1'b1;
						start_kind = cicpc_pkg::JOB_EDGE_CLOSE;
					end
				end
			end
			default: start_job = 1'b0;
		endcase
	end

	// point selection for the job about to start
	always_comb begin
		sel_a = prior_q;
		sel_b = cur_q;
		sel_c = cur_q;
		case (start_kind)
			cicpc_pkg::JOB_EDGE: begin
				sel_a = prior_q;
				sel_b = (state_q == cicpc_pkg::ST_IDLE) ? pt_t'{vertex_x, vertex_y} : cur_q;
			end
			cicpc_pkg::JOB_TURN: begin
				sel_a = vbp_q;
				sel_b = prior_q;
				sel_c = cur_q;
			end
			cicpc_pkg::JOB_EDGE_CLOSE: begin
				// prior takes cur in this same cycle
				sel_a = cur_q;
				sel_b = first_q;
			end
			cicpc_pkg::JOB_TURN_CLOSE_A: begin
				sel_a = vbp_q;
				sel_b = prior_q;
				sel_c = first_q;
			end
			cicpc_pkg::JOB_TURN_CLOSE_B: begin
				sel_a = prior_q;
				sel_b = first_q;
				sel_c = second_q;
			end
			default: sel_a = prior_q;
		endcase
	end

	// operand select
	function automatic logic signed [MW-1:0] pick(input cicpc_pkg::opd_t s,
			input logic signed [DW-1:0] ax, input logic signed [DW-1:0] ay,
			input logic signed [DW-1:0] bx, input logic signed [DW-1:0] by,
			input logic signed [DW-1:0] ex, input logic signed [DW-1:0] ey,
			input logic signed [DW-1:0] vx, input logic signed [DW-1:0] vy,
			input logic [cicpc_pkg::RADIUS_BITS-1:0] r,
			input logic [cicpc_pkg::R2_BITS-1:0] r2,
			input logic [CW-1:0] cm, input logic [CW-1:0] em);
		logic signed [MW-1:0] v;
		v = '0;
		case (s)
			cicpc_pkg::OPD_AX:  v = MW'(ax);
			cicpc_pkg::OPD_AY:  v = MW'(ay);
			cicpc_pkg::OPD_BX:  v = MW'(bx);
			cicpc_pkg::OPD_BY:  v = MW'(by);
			cicpc_pkg::OPD_EX:  v = MW'(ex);
			cicpc_pkg::OPD_EY:  v = MW'(ey);
			cicpc_pkg::OPD_VX:  v = MW'(vx);
			cicpc_pkg::OPD_VY:  v = MW'(vy);
			cicpc_pkg::OPD_R:   v = MW'(r);
			cicpc_pkg::OPD_R2:  v = MW'(r2);
			cicpc_pkg::OPD_ONE: v = MW'(1);
			cicpc_pkg::OPD_CHI: v = MW'(cm[CW-1:DW]);
			cicpc_pkg::OPD_CLO: v = MW'(cm[DW-1:0]);
			cicpc_pkg::OPD_EHI: v = MW'(em[CW-1:DW]);
			cicpc_pkg::OPD_ELO: v = MW'(em[DW-1:0]);
			default: v = '0;
		endcase
		return v;
	endfunction

	assign opa = pick(uop.opa, ax_q, ay_q, bx_q, by_q, ex_q, ey_q, vx_q, vy_q,
		peg_radius_q, r2_q, cmag_q, e_q);
	assign opb = pick(uop.opb, ax_q, ay_q, bx_q, by_q, ex_q, ey_q, vx_q, vy_q,
		peg_radius_q, r2_q, cmag_q, e_q);

	// accumulate stage: load, add or subtract a shifted product
	always_comb begin
		acc_base = (ctl_s1.mode == cicpc_pkg::ACC_LOAD) ? '0 : acc_q;
		case (ctl_s1.shift)
			cicpc_pkg::SH_ONE: acc_term = AW'(prod_s1) <<< DW;
			cicpc_pkg::SH_TWO: acc_term = AW'(prod_s1) <<< (2 * DW);
			default:           acc_term = AW'(prod_s1);
		endcase
		if (ctl_s1.mode == cicpc_pkg::ACC_SUB)
			acc_nxt = acc_base - acc_term;
		else
			acc_nxt = acc_base + acc_term;
		acc_neg  = acc_nxt[AW-1];
		acc_zero = (acc_nxt == '0);
		acc_abs  = acc_neg ? -acc_nxt : acc_nxt;
	end

	// turn code from the cross product just finished
	assign turn_code = acc_zero ? cicpc_pkg::TURN_NONE :
		(acc_neg ? cicpc_pkg::TURN_RIGHT : cicpc_pkg::TURN_LEFT);

	// edge verdict pieces: nearest feature decides the distance test
	assign zero_len = (ex_q == '0) && (ey_q == '0);
	assign near     = (zero_len || da_neg_q) ? an_q : (db_pos_q ? bn_q : cn_q);
	assign on_edge  = cab_zero_q && dab_neg_q;
	assign ay_le0   = ay_q[DW-1] || (ay_q == '0);
	assign by_le0   = by_q[DW-1] || (by_q == '0);

	// result slot is free when nothing waits or the waiting item leaves now
	assign out_load = (state_q == cicpc_pkg::ST_OUT) && (!vld_out_q || !out_stall);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peg_x_q      <= '0;
			peg_y_q      <= '0;
			peg_radius_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cicpc_pkg::CFG_PEG_X:      peg_x_q      <= cfg_data;
				cicpc_pkg::CFG_PEG_Y:      peg_y_q      <= cfg_data;
				cicpc_pkg::CFG_PEG_RADIUS: peg_radius_q <= cfg_data[cicpc_pkg::RADIUS_BITS-1:0];
				default: peg_x_q <= peg_x_q;
			endcase
		end
	end

	// multiplier register and accumulator, payload only
	always_ff @(posedge clk) begin
		prod_s1 <= opa * opb;
		ctl_s1  <= uop.ctl;
		if (vld_s1) begin
			acc_q <= acc_nxt;
			case (ctl_s1.cap)
				cicpc_pkg::CAP_R2:  r2_q       <= acc_nxt[cicpc_pkg::R2_BITS-1:0];
				cicpc_pkg::CAP_CAB: cab_zero_q <= acc_zero;
				cicpc_pkg::CAP_DAB: dab_neg_q  <= acc_neg;
				cicpc_pkg::CAP_K: begin
					k_pos_q <= !acc_neg && !acc_zero;
					k_neg_q <= acc_neg;
					cmag_q  <= acc_abs[CW-1:0];
				end
				cicpc_pkg::CAP_DA:  da_neg_q <= !acc_neg && !acc_zero;
				cicpc_pkg::CAP_DB:  db_pos_q <= acc_neg;
				cicpc_pkg::CAP_AN:  an_q     <= acc_neg;
				cicpc_pkg::CAP_BN:  bn_q     <= acc_neg;
				cicpc_pkg::CAP_E:   e_q      <= acc_nxt[CW-1:0];
				cicpc_pkg::CAP_CN:  cn_q     <= acc_neg;
				default: cn_q <= cn_q;
			endcase
		end
		if (start_job) begin
			ax_q <= DW'(sel_a.x) - DW'(peg_x_q);
			ay_q <= DW'(sel_a.y) - DW'(peg_y_q);
			bx_q <= DW'(sel_b.x) - DW'(peg_x_q);
			by_q <= DW'(sel_b.y) - DW'(peg_y_q);
			ex_q <= DW'(sel_b.x) - DW'(sel_a.x);
			ey_q <= DW'(sel_b.y) - DW'(sel_a.y);
			vx_q <= DW'(sel_c.x) - DW'(sel_b.x);
			vy_q <= DW'(sel_c.y) - DW'(sel_b.y);
		end
		// vertex history
		if (in_acc) begin
			cur_q  <= pt_t'{vertex_x, vertex_y};
			last_q <= last_vertex;
			if (cnt_q == 2'd0) begin
				first_q <= pt_t'{vertex_x, vertex_y};
				vbp_q   <= prior_q;
				prior_q <= pt_t'{vertex_x, vertex_y};
			end
			if (cnt_q == 2'd1)
				second_q <= pt_t'{vertex_x, vertex_y};
		end
		if (do_shift) begin
			vbp_q   <= prior_q;
			prior_q <= cur_q;
		end
		if (give_verdict)
			pend_q <= verdict_nxt;
		if (out_load)
			verdict_q <= pend_q;
	end

	// sequencer and polygon control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cicpc_pkg::ST_IDLE;
			job_q     <= cicpc_pkg::JOB_EDGE;
			op_q      <= cicpc_pkg::EDGE_START;
			vld_s1    <= 1'b0;
			cnt_q     <= '0;
			turn_q    <= cicpc_pkg::TURN_NONE;
			wind_q    <= '0;
			ill_q     <= 1'b0;
			misfit_q  <= 1'b0;
			vld_out_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == cicpc_pkg::ST_RUN);

			// turn test result lands here
			if (vld_s1 && ctl_s1.cap == cicpc_pkg::CAP_TURN &&
					turn_code != cicpc_pkg::TURN_NONE) begin
				if (turn_q == cicpc_pkg::TURN_NONE)
					turn_q <= turn_code;
				else if (turn_q != turn_code)
					ill_q <= 1'b1;
			end

			// edge results: on-edge, distance and winding crossing
			if (state_q == cicpc_pkg::ST_APPLY &&
					(job_q == cicpc_pkg::JOB_EDGE || job_q == cicpc_pkg::JOB_EDGE_CLOSE)) begin
				if (on_edge || near)
					misfit_q <= 1'b1;
				if (k_pos_q && ay_le0 && !by_le0)
					wind_q <= wind_q + 16'd1;
				else if (k_neg_q && by_le0 && !ay_le0)
					wind_q <= wind_q - 16'd1;
			end

			if (in_acc && cnt_q == 2'd0)
				cnt_q <= 2'd1;
			if (do_shift)
				cnt_q <= cnt_nxt;

			// output slot: filled by a new verdict, emptied when taken
			if (out_load)
				vld_out_q <= 1'b1;
			else if (!out_stall)
				vld_out_q <= 1'b0;

			case (state_q)
				cicpc_pkg::ST_IDLE: begin
					if (start_job)
						state_q <= cicpc_pkg::ST_RUN;
					else if (give_verdict)
						state_q <= cicpc_pkg::ST_OUT;
				end
				cicpc_pkg::ST_RUN: begin
					op_q <= op_q + 1'b1;
					if (uop.last)
						state_q <= cicpc_pkg::ST_DRAIN;
				end
				cicpc_pkg::ST_DRAIN: state_q <= cicpc_pkg::ST_APPLY;
				cicpc_pkg::ST_APPLY: begin
					if (start_job)
						state_q <= cicpc_pkg::ST_RUN;
					else if (give_verdict)
						state_q <= cicpc_pkg::ST_OUT;
					else
						state_q <= cicpc_pkg::ST_IDLE;
				end
				cicpc_pkg::ST_OUT: begin
					if (out_load) begin
						// polygon done, start clean
						cnt_q    <= '0;
						turn_q   <= cicpc_pkg::TURN_NONE;
						wind_q   <= '0;
						ill_q    <= 1'b0;
						misfit_q <= 1'b0;
						state_q  <= cicpc_pkg::ST_IDLE;
					end
				end
				default: state_q <= cicpc_pkg::ST_IDLE;
			endcase

			if (start_job) begin
				job_q <= start_kind;
				if (start_kind == cicpc_pkg::JOB_EDGE || start_kind == cicpc_pkg::JOB_EDGE_CLOSE)
					op_q <= cicpc_pkg::EDGE_START;
				else
					op_q <= cicpc_pkg::TURN_START;
			end
		end
	end

endmodule

@@ tb/tb_circle_in_convex_polygon_check.sv @@
`timescale 1ns / 1ps

module tb_circle_in_convex_polygon_check;

	localparam int CB = 16;
	localparam int DRAIN_CYCLES = 120;

	typedef struct packed {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic                 last;
	} vertex_item_t;

	typedef logic signed [127:0] wide_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [CB-1:0] vertex_x;
	logic signed [CB-1:0] vertex_y;
	logic last_vertex;
	logic out_valid;
	logic out_stall;
	logic [cicpc_pkg::VERDICT_BITS-1:0] verdict;
	logic cfg_valid;
	logic cfg_ready;
	logic [cicpc_pkg::CFG_IDX_BITS-1:0] cfg_index;
	logic [cicpc_pkg::CFG_DATA_BITS-1:0] cfg_data;

	circle_in_convex_polygon_check #(.COORD_BITS(CB)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .last_vertex(last_vertex),
		.out_valid(out_valid), .out_stall(out_stall), .verdict(verdict),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// pending vertex items and verdicts still to come
	vertex_item_t vertex_queue[$];
	logic [cicpc_pkg::VERDICT_BITS-1:0] verdict_queue[$];
	int error_count = 0;

	// knobs for driver and receiver; idle_enable is shared by both
	bit idle_enable = 1'b1;
	bit rx_hold = 1'b0;
	int tx_gap = 0;
	int rx_gap = 0;

	// predictor copy of the peg registers and the polygon state
	logic signed [63:0] peg_cx, peg_cy, peg_r;
	logic signed [63:0] fst_x, fst_y, snd_x, snd_y, prv_x, prv_y, pp_x, pp_y;
	logic [1:0] orient;
	logic [15:0] winding;
	int n_vertices;
	bit ill_seen, misfit_seen;

	always #5 clk = ~clk;

	function automatic int sign_of(input wide_t v);
		return (v < 0) ? -1 : ((v > 0) ? 1 : 0);
	endfunction

	function automatic wide_t cross2(input wide_t ax, ay, bx, by);
		return ax * by - ay * bx;
	endfunction

	function automatic wide_t dot2(input wide_t ax, ay, bx, by);
		return ax * bx + ay * by;
	endfunction

	function automatic void clear_polygon();
		fst_x = 0; fst_y = 0; snd_x = 0; snd_y = 0;
		prv_x = 0; prv_y = 0; pp_x = 0; pp_y = 0;
		orient = cicpc_pkg::TURN_NONE;
		winding = '0;
		n_vertices = 0;
		ill_seen = 0;
		misfit_seen = 0;
	endfunction

	// one edge: centre on edge, winding crossing and clearance
	function automatic void edge_test(input wide_t px, py, qx, qy);
		wide_t ax, ay, bx, by, ex, ey, r2, c, dist_a, dist_b;
		int k;
		bit near;
		ax = px - peg_cx; ay = py - peg_cy;
		bx = qx - peg_cx; by = qy - peg_cy;
		ex = qx - px; ey = qy - py;
		r2 = peg_r * peg_r;
		if (cross2(ax, ay, bx, by) == 0 && dot2(ax, ay, bx, by) < 0)
			misfit_seen = 1;
		k = sign_of(cross2(ex, ey, -ax, -ay));
		if (k > 0 && ay <= 0 && by > 0) winding = winding + 16'd1;
		if (k < 0 && by <= 0 && ay > 0) winding = winding - 16'd1;
		dist_a = dot2(ax, ay, ax, ay);
		dist_b = dot2(bx, by, bx, by);
		if (ex == 0 && ey == 0)
			near = dist_a < r2;
		else if (dot2(ex, ey, -ax, -ay) < 0)
			near = dist_a < r2;
		else if (dot2(ex, ey, -bx, -by) > 0)
			near = dist_b < r2;
		else begin
			c = cross2(ex, ey, -ax, -ay);
			near = c * c < r2 * dot2(ex, ey, ex, ey);
		end
		if (near) misfit_seen = 1;
	endfunction

	function automatic void turn_test(input wide_t ax, ay, bx, by, cx, cy);
		int s;
		logic [1:0] code;
		s = sign_of(cross2(bx - ax, by - ay, cx - bx, cy - by));
		code = (s > 0) ? cicpc_pkg::TURN_LEFT :
			((s < 0) ? cicpc_pkg::TURN_RIGHT : cicpc_pkg::TURN_NONE);
		if (code == cicpc_pkg::TURN_NONE) return;
		if (orient == cicpc_pkg::TURN_NONE) orient = code;
		else if (orient != code) ill_seen = 1;
	endfunction

	// advances the polygon state by one vertex and queues any verdict
	function automatic void predict_vertex(input vertex_item_t it);
		logic signed [63:0] vx, vy;
		logic [cicpc_pkg::VERDICT_BITS-1:0] v;
		vx = it.x; vy = it.y;
		if (n_vertices == 0) begin
			fst_x = vx; fst_y = vy;
		end else begin
			edge_test(prv_x, prv_y, vx, vy);
			if (n_vertices >= 2) turn_test(pp_x, pp_y, prv_x, prv_y, vx, vy);
		end
		if (n_vertices == 1) begin
			snd_x = vx; snd_y = vy;
		end
		pp_x = prv_x; pp_y = prv_y;
		prv_x = vx; prv_y = vy;
		if (n_vertices < cicpc_pkg::MIN_VERTICES) n_vertices++;
		if (!it.last) return;
		if (n_vertices < cicpc_pkg::MIN_VERTICES)
			v = cicpc_pkg::VERDICT_ILL;
		else begin
			// closing edge plus both wrap turns
			edge_test(prv_x, prv_y, fst_x, fst_y);
			turn_test(pp_x, pp_y, prv_x, prv_y, fst_x, fst_y);
			turn_test(prv_x, prv_y, fst_x, fst_y, snd_x, snd_y);
			if (ill_seen) v = cicpc_pkg::VERDICT_ILL;
			else if (misfit_seen || winding == 0) v = cicpc_pkg::VERDICT_NOT_FIT;
			else v = cicpc_pkg::VERDICT_FIT;
		end
		clear_polygon();
		verdict_queue = {verdict_queue, v};
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		error_count++;
	endtask

	// driver: offers the head of the queue, predicts on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			vertex_x <= '0;
			vertex_y <= '0;
			last_vertex <= 1'b0;
			tx_gap <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_vertex('{vertex_x, vertex_y, last_vertex});
				void'(vertex_queue.pop_front());
			end
			if (in_valid && in_stall) begin
				// payload held while stalled
			end else if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				in_valid <= 1'b0;
			end else if (idle_enable && $urandom_range(0, 9) == 0) begin
				tx_gap <= $urandom_range(0, 13);
				in_valid <= 1'b0;
			end else begin
				// the item just popped is gone; look at what remains
				if (vertex_queue.size() > 0) begin
					in_valid <= 1'b1;
					vertex_x <= vertex_queue[0].x;
					vertex_y <= vertex_queue[0].y;
					last_vertex <= vertex_queue[0].last;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stall bursts plus the long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_gap <= 0;
		end else if (rx_hold) begin
			out_stall <= 1'b1;
		end else if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1;
			out_stall <= 1'b1;
		end else if (idle_enable && $urandom_range(0, 7) == 0) begin
			rx_gap <= $urandom_range(0, 13);
			out_stall <= 1'b1;
		end else
			out_stall <= 1'b0;
	end

	// monitor: checks each verdict against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (verdict_queue.size() == 0)
				report_mismatch($sformatf("unexpected verdict %0d", verdict));
			else if (verdict !== verdict_queue[0]) begin
				report_mismatch($sformatf("verdict %0d, predicted %0d",
					verdict, verdict_queue[0]));
				void'(verdict_queue.pop_front());
			end else
				void'(verdict_queue.pop_front());
		end
	end

	// register write through the handshake, mirrored into the predictor
	task automatic write_reg(input logic [cicpc_pkg::CFG_IDX_BITS-1:0] idx,
			input logic [cicpc_pkg::CFG_DATA_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			cicpc_pkg::CFG_PEG_X: peg_cx = $signed(data);
			cicpc_pkg::CFG_PEG_Y: peg_cy = $signed(data);
			cicpc_pkg::CFG_PEG_RADIUS: peg_r = {49'd0, data[14:0]};
			default: ;
		endcase
	endtask

	task automatic set_peg(input int x, input int y, input int r);
		write_reg(cicpc_pkg::CFG_PEG_X, x[15:0]);
		write_reg(cicpc_pkg::CFG_PEG_Y, y[15:0]);
		write_reg(cicpc_pkg::CFG_PEG_RADIUS, r[15:0]);
	endtask

	task automatic wait_idle();
		while (vertex_queue.size() > 0 || in_valid || verdict_queue.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic push_vertex(input int x, input int y, input bit last);
		vertex_item_t it;
		it.x = x[CB-1:0];
		it.y = y[CB-1:0];
		it.last = last;
		vertex_queue = {vertex_queue, it};
	endtask

	// regular-ish convex polygon around (cx, cy), either winding direction
	task automatic push_convex(input int cx, input int cy, input int rad, input int n,
			input bit cw);
		real a;
		int x, y;
		for (int i = 0; i < n; i++) begin
			a = 6.2831853 * (cw ? (n - i) : i) / n;
			x = cx + $rtoi(rad * $cos(a));
			y = cy + $rtoi(rad * $sin(a));
			if (x > 32767) x = 32767;
			if (x < -32768) x = -32768;
			if (y > 32767) y = 32767;
			if (y < -32768) y = -32768;
			push_vertex(x, y, i == n - 1);
		end
	endtask

	task automatic push_random_polygon();
		int n, kind, r;
		kind = $urandom_range(0, 9);
		n = $urandom_range(3, 8);
		r = $urandom_range(1, 30000);
		if (kind < 7)
			push_convex(int'(peg_cx) + $urandom_range(0, 200) - 100,
				int'(peg_cy) + $urandom_range(0, 200) - 100, r, n, $urandom_range(0, 1));
		else if (kind == 7) begin
			// random noise, any length including degenerate
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				push_vertex($urandom, $urandom, i == n - 1);
		end else if (kind == 8) begin
			// full-range corners, some collinear runs
			for (int i = 0; i < n; i++)
				push_vertex($urandom_range(0, 1) ? 32767 : -32768,
					$urandom_range(0, 2) == 0 ? 0 : ($urandom_range(0, 1) ? 32767 : -32768),
					i == n - 1);
		end else begin
			// collinear points on a line
			for (int i = 0; i < n; i++)
				push_vertex(i * 100, i * 50, i == n - 1);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		peg_cx = 0; peg_cy = 0; peg_r = 0;
		clear_polygon();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: too few vertices, fit, misfit, ill-formed, degenerate cases
		set_peg(0, 0, 10);
		push_vertex(5, 5, 1);
		push_vertex(5, 5, 0); push_vertex(9, 9, 1);
		push_convex(0, 0, 1000, 4, 0);
		push_convex(0, 0, 1000, 5, 1);
		push_vertex(0, -5, 0); push_vertex(100, 5, 0); push_vertex(-100, 5, 1);
		push_vertex(-10, 0, 0); push_vertex(10, 0, 0); push_vertex(0, 20, 1);
		push_vertex(0, 0, 0); push_vertex(0, 0, 0); push_vertex(0, 0, 1);
		push_vertex(0, 0, 0); push_vertex(100, 0, 0); push_vertex(100, 100, 0);
		push_vertex(120, 20, 1);
		wait_idle();
		set_peg(32767, -32768, 32767);
		push_vertex(-32768, -32768, 0); push_vertex(32767, -32768, 0);
		push_vertex(32767, 32767, 0); push_vertex(-32768, 32767, 1);
		wait_idle();
		set_peg(-32768, 32767, 0);
		push_vertex(-32768, -32768, 0); push_vertex(32767, 32767, 0);
		push_vertex(-32768, 32767, 1);
		wait_idle();

		// random phases over several peg settings
		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 5) idle_enable = 1'b0;
			set_peg($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
				(phase == 1) ? 0 : $urandom_range(0, 32767));
			for (int p = 0; p < 42; p++) push_random_polygon();
			if (phase == 2) begin
				rx_hold = 1'b1;
				repeat (600) @(posedge clk);
				rx_hold = 1'b0;
			end
			wait_idle();
		end

		if (error_count == 0 && verdict_queue.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
